// ----- rtl/core/sitb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sitb_pkg
// Shared types and constants of the self-id tree builder.
// ----------------------------------------------------------------------------
package sitb_pkg;

  localparam int PORTS      = 16;
  localparam int MAX_NODES  = 63;
  localparam int SEEN_PORTS = (PORTS > 16) ? 16 : PORTS;
  localparam int STACK_SLOTS = 63;

  localparam int ID_W    = 6;
  localparam int PORT_W  = 4;
  localparam int HGT_W   = 6;
  localparam int REACH_W = HGT_W + 1;
  localparam int PST_W   = 32;

  // port state codes
  localparam logic [1:0] PS_PARENT = 2'd2;
  localparam logic [1:0] PS_CHILD  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_LINK = 2'd0;
  localparam logic [1:0] KIND_SUM  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_BAD_ID     = 3'd1;
  localparam logic [2:0] ERR_EMPTY      = 3'd2;
  localparam logic [2:0] ERR_PARENTLESS = 3'd4;
  localparam logic [2:0] ERR_STACK_LEFT = 3'd5;

  typedef struct packed {
    logic [HGT_W-1:0]  height;
    logic [PORT_W-1:0] pport;
    logic [ID_W-1:0]   id;
  } stack_entry_t;

  typedef struct packed {
    logic       load;
    logic       clr_run;
    logic       clr_drop;
    logic       scan_init;
    logic       port_dec;
    logic       pop;
    logic       emit_link;
    logic       upd;
    logic       push;
    logic       emit_sum;
    logic       fail;
    logic [2:0] err_code;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic rec_last;
    logic id_bad;
    logic port_child;
    logic port_zero;
    logic depth_zero;
    logic depth_full;
    logic has_parent;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ----- rtl/core/sitb_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sitb_ctrl
// Controller: walks one record through check, port scan, pops, update and finish.
// ----------------------------------------------------------------------------
module sitb_ctrl import sitb_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic    in_last_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_SCAN   = 6'b000100,
    S_POP    = 6'b001000,
    S_UPD    = 6'b010000,
    S_FINISH = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.drop) begin
            // dropping after an error until the last marker
            if (in_last_i) begin
              cmd_o.clr_run  = 1'b1;
              cmd_o.clr_drop = 1'b1;
            end
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (status_i.id_bad) begin
          if (status_i.out_free) begin
            cmd_o.fail     = 1'b1;
            cmd_o.err_code = ERR_BAD_ID;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status_i.port_child) begin
          if (status_i.depth_zero) begin
            if (status_i.out_free) begin
              cmd_o.fail     = 1'b1;
              cmd_o.err_code = ERR_EMPTY;
              state_d        = S_IDLE;
            end
          end else begin
            cmd_o.pop = 1'b1;
            state_d   = S_POP;
          end
        end else if (status_i.port_zero) begin
          state_d = S_UPD;
        end else begin
          cmd_o.port_dec = 1'b1;
        end
      end
      S_POP: begin
        if (status_i.out_free) begin
          cmd_o.emit_link = 1'b1;
          if (status_i.port_zero) begin
            state_d = S_UPD;
          end else begin
            cmd_o.port_dec = 1'b1;
            state_d        = S_SCAN;
          end
        end
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_FINISH;
      end
      S_FINISH: begin
        if (!status_i.rec_last) begin
          if (!status_i.has_parent) begin
            if (status_i.out_free) begin
              cmd_o.fail     = 1'b1;
              cmd_o.err_code = ERR_PARENTLESS;
              state_d        = S_IDLE;
            end
          end else if (status_i.depth_full) begin
            if (status_i.out_free) begin
              cmd_o.fail     = 1'b1;
              cmd_o.err_code = ERR_STACK_LEFT;
              state_d        = S_IDLE;
            end
          end else begin
            cmd_o.push = 1'b1;
            state_d    = S_IDLE;
          end
        end else if (status_i.out_free) begin
          if (!status_i.depth_zero) begin
            cmd_o.fail     = 1'b1;
            cmd_o.err_code = ERR_STACK_LEFT;
          end else begin
            cmd_o.emit_sum = 1'b1;
            cmd_o.clr_run  = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/sitb_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sitb_datapath
// Record registers, pending stack memory, run state and result register.
// ----------------------------------------------------------------------------
module sitb_datapath import sitb_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [ID_W-1:0]   in_id_i,
  input  wire logic              in_link_i,
  input  wire logic              in_cont_i,
  input  wire logic [PST_W-1:0]  in_ports_i,
  input  wire logic              in_last_i,
  input  wire cmd_t              cmd_i,
  output status_t                status_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             out_kind_o,
  output logic [ID_W-1:0]        out_parent_id_o,
  output logic [PORT_W-1:0]      out_parent_port_o,
  output logic [ID_W-1:0]        out_child_id_o,
  output logic [PORT_W-1:0]      out_child_port_o,
  output logic [ID_W-1:0]        out_node_count_o,
  output logic                   out_irm_valid_o,
  output logic [ID_W-1:0]        out_irm_id_o,
  output logic [HGT_W-1:0]       out_diameter_o,
  output logic [2:0]             out_err_o,
  output logic                   out_last_o
);

  // current record
  logic [ID_W-1:0]   rec_id_q;
  logic              rec_link_q;
  logic              rec_cont_q;
  logic [PST_W-1:0]  rec_ports_q;
  logic              rec_last_q;

  // run state
  logic [ID_W-1:0]   exp_id_q;
  logic [ID_W-1:0]   depth_q;
  logic [HGT_W-1:0]  best_q;
  logic              irm_found_q;
  logic [ID_W-1:0]   irm_node_q;
  logic              drop_q;

  // scan state
  logic [PORT_W-1:0]  port_q;
  logic [REACH_W-1:0] top1_q, top2_q;

  stack_entry_t mem [STACK_SLOTS];
  stack_entry_t rd_q;

  logic               out_valid_q;
  logic               out_free;
  logic               out_load;
  logic [1:0]         port_st;
  logic [PORT_W-1:0]  low_parent;
  logic               has_parent;
  logic [REACH_W-1:0] reach;
  logic [REACH_W:0]   span;
  logic [ID_W-1:0]    top_addr;

  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = cmd_i.emit_link || cmd_i.emit_sum || cmd_i.fail;
  assign port_st  = rec_ports_q[2*port_q +: 2];
  assign reach    = REACH_W'(rd_q.height) + REACH_W'(1);
  assign span     = (REACH_W+1)'(top1_q) + (REACH_W+1)'(top2_q);
  assign top_addr = depth_q - ID_W'(1);

  // lowest parent-state port
  always_comb begin
    low_parent = '0;
    has_parent = 1'b0;
    for (int p = SEEN_PORTS - 1; p >= 0; p--) begin
      if (rec_ports_q[2*p +: 2] == PS_PARENT) begin
        low_parent = PORT_W'(p);
        has_parent = 1'b1;
      end
    end
  end

  always_comb begin
    status_o.drop       = drop_q;
    status_o.rec_last   = rec_last_q;
    status_o.id_bad     = (rec_id_q != exp_id_q) || (rec_id_q >= ID_W'(MAX_NODES));
    status_o.port_child = (port_st == PS_CHILD);
    status_o.port_zero  = (port_q == '0);
    status_o.depth_zero = (depth_q == '0);
    status_o.depth_full = (depth_q >= ID_W'(STACK_SLOTS));
    status_o.has_parent = has_parent;
    status_o.out_free   = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rec_id_q    <= in_id_i;
      rec_link_q  <= in_link_i;
      rec_cont_q  <= in_cont_i;
      rec_ports_q <= in_ports_i;
      rec_last_q  <= in_last_i;
    end
    if (cmd_i.scan_init) begin
      port_q <= PORT_W'(SEEN_PORTS - 1);
    end else if (cmd_i.port_dec) begin
      port_q <= port_q - PORT_W'(1);
    end
    if (cmd_i.scan_init) begin
      top1_q <= '0;
      top2_q <= '0;
    end else if (cmd_i.emit_link) begin
      if (reach > top1_q) begin
        top2_q <= top1_q;
        top1_q <= reach;
      end else if (reach > top2_q) begin
        top2_q <= reach;
      end
    end
  end

  // pending stack memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[depth_q] <= '{height: top1_q[HGT_W-1:0], pport: low_parent, id: rec_id_q};
    end
    if (cmd_i.pop) begin
      rd_q <= mem[top_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_id_q    <= '0;
      depth_q     <= '0;
      best_q      <= '0;
      irm_found_q <= 1'b0;
      irm_node_q  <= '0;
      drop_q      <= 1'b0;
    end else begin
      if (cmd_i.clr_run || cmd_i.fail) begin
        exp_id_q    <= '0;
        depth_q     <= '0;
        best_q      <= '0;
        irm_found_q <= 1'b0;
        irm_node_q  <= '0;
      end else begin
        if (cmd_i.pop) begin
          depth_q <= top_addr;
        end else if (cmd_i.push) begin
          depth_q  <= depth_q + ID_W'(1);
          exp_id_q <= rec_id_q + ID_W'(1);
        end
        if (cmd_i.upd) begin
          if (rec_cont_q && rec_link_q) begin
            irm_found_q <= 1'b1;
            irm_node_q  <= rec_id_q;
          end
          if (span > (REACH_W+1)'(best_q)) begin
            best_q <= span[HGT_W-1:0];
          end
        end
      end
      if (cmd_i.fail) begin
        drop_q <= !rec_last_q;
      end else if (cmd_i.clr_drop) begin
        drop_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_o        <= KIND_LINK;
      out_parent_id_o   <= '0;
      out_parent_port_o <= '0;
      out_child_id_o    <= '0;
      out_child_port_o  <= '0;
      out_node_count_o  <= '0;
      out_irm_valid_o   <= 1'b0;
      out_irm_id_o      <= '0;
      out_diameter_o    <= '0;
      out_err_o         <= ERR_NONE;
      out_last_o        <= 1'b0;
      if (cmd_i.emit_link) begin
        out_parent_id_o   <= rec_id_q;
        out_parent_port_o <= port_q;
        out_child_id_o    <= rd_q.id;
        out_child_port_o  <= rd_q.pport;
      end else if (cmd_i.emit_sum) begin
        out_kind_o       <= KIND_SUM;
        out_node_count_o <= rec_id_q + ID_W'(1);
        out_irm_valid_o  <= irm_found_q;
        out_irm_id_o     <= irm_found_q ? irm_node_q : '0;
        out_diameter_o   <= best_q;
        out_last_o       <= 1'b1;
      end else begin
        out_kind_o <= KIND_ERR;
        out_err_o  <= cmd_i.err_code;
        out_last_o <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- rtl/core/self_id_tree_builder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// self_id_tree_builder
// Rebuilds bus tree links from self-id records, then reports a summary or an error.
// ----------------------------------------------------------------------------
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   tdata: record, tlast: root
//   m_axis    out  m_axis_tvalid/m_axis_tready   tdata: result, tuser: kind,
//                                                tlast: end of run
//
// every port of a record is scanned serially from the highest down, one port
// per cycle while no child port is popped; each child port adds a pop state
// for the registered stack memory read, which waits on the result register.
// records dropped after an error are taken without leaving the idle state.
// reset clears the controller and run state; the stack memory needs no clear.
// a stalled result holds the record in progress until the result register frees.
// ----------------------------------------------------------------------------
module self_id_tree_builder import sitb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [5:0] node_id, [6] link_active, [7] contender, [39:8] port_states
  input  wire logic [39:0] s_axis_tdata,
  // is_last
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [5:0] parent_id, [9:6] parent_port, [15:10] child_id, [19:16] child_port,
  // [25:20] node_count, [26] irm_valid, [32:27] irm_id, [38:33] diameter_hops,
  // [41:39] error_code, [47:42] zero
  output logic [47:0]      m_axis_tdata,
  // [1:0] result_kind
  output logic [1:0]       m_axis_tuser,
  // last_of_run
  output logic             m_axis_tlast
);

  cmd_t    cmd;
  status_t status;

  logic [ID_W-1:0]   parent_id;
  logic [PORT_W-1:0] parent_port;
  logic [ID_W-1:0]   child_id;
  logic [PORT_W-1:0] child_port;
  logic [ID_W-1:0]   node_count;
  logic              irm_valid;
  logic [ID_W-1:0]   irm_id;
  logic [HGT_W-1:0]  diameter;
  logic [2:0]        err_code;

  sitb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sitb_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_id_i           (s_axis_tdata[5:0]),
    .in_link_i         (s_axis_tdata[6]),
    .in_cont_i         (s_axis_tdata[7]),
    .in_ports_i        (s_axis_tdata[39:8]),
    .in_last_i         (s_axis_tlast),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_kind_o        (m_axis_tuser),
    .out_parent_id_o   (parent_id),
    .out_parent_port_o (parent_port),
    .out_child_id_o    (child_id),
    .out_child_port_o  (child_port),
    .out_node_count_o  (node_count),
    .out_irm_valid_o   (irm_valid),
    .out_irm_id_o      (irm_id),
    .out_diameter_o    (diameter),
    .out_err_o         (err_code),
    .out_last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, err_code, diameter, irm_id, irm_valid, node_count,
                         child_port, child_id, parent_port, parent_id};

`ifndef NO_ASSERTIONS
  // only summaries and errors end a run
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != KIND_LINK)))
    else $error("tlast does not match result kind");

  // an error result always carries a code
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_ERR) |-> (m_axis_tdata[41:39] != ERR_NONE))
    else $error("error result without code");

  // a tree of n nodes has a diameter below n
  a_diameter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_SUM) |->
      (m_axis_tdata[38:33] < m_axis_tdata[25:20]))
    else $error("diameter not below node count");

  // no new record while one is in progress
  a_one_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !status.drop) |=> !s_axis_tready)
    else $error("record accepted during processing");
`endif

endmodule
`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the self-id tree builder. Self-id records, both
// directed and random trees with injected faults, go in through the input
// stream while the output stream stalls. A local tree predictor computes the
// link, summary and error results, and each result is compared in order.
// ----------------------------------------------------------------------------
module tb;
  import sitb_pkg::*;

  localparam int         RANDOM_RECS = 380;
  localparam int         CYCLE_LIMIT = 1000000;
  localparam int         TAIL_CYCLES = 200;
  localparam int         MAX_PRINTS  = 50;
  localparam logic [1:0] PS_ABSENT   = 2'd0;
  localparam logic [1:0] PS_UNCONN   = 2'd1;

  typedef enum int {F_NONE, F_BAD_ID, F_EXTRA_CHILD, F_NO_PARENT, F_EARLY_ROOT, F_ID63} fault_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_SLOW} rx_mode_e;

  typedef struct {
    logic [5:0]  id;
    logic        link;
    logic        cont;
    logic [31:0] ports;
    logic        last;
    bit          hold_drain;
  } self_id_rec_t;

  typedef struct {
    int kind;
    int parent_id;
    int parent_port;
    int child_id;
    int child_port;
    int node_count;
    int irm_valid;
    int irm_id;
    int diameter;
    int err;
    int pad;
    int last;
  } tree_res_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  self_id_tree_builder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  self_id_rec_t rec_q[$];
  self_id_rec_t cur_rec;
  tree_res_t    tree_results_q[$];

  int err_count  = 0;
  int n_taken    = 0;
  int n_gen      = 0;
  int n_links    = 0;
  int n_sums     = 0;
  int n_errs     = 0;
  int cycle_cnt  = 0;
  int gap_left   = 0;
  int burst_left = 0;

  // predictor state
  stack_entry_t pend_stk[STACK_SLOTS];
  int           pend_depth = 0;
  int           next_id    = 0;
  int           best_diam  = 0;
  bit           irm_seen   = 1'b0;
  int           irm_node   = 0;
  bit           dropping   = 1'b0;

  task automatic flag_mismatch(input string msg);
    if (err_count < MAX_PRINTS) $display("mismatch @%0d: %s", cycle_cnt, msg);
    err_count++;
  endtask

  task automatic cmp_field(input string name, input int got, input int want);
    if (got != want) flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  function automatic void clear_run_state();
    pend_depth = 0;
    next_id    = 0;
    best_diam  = 0;
    irm_seen   = 1'b0;
    irm_node   = 0;
  endfunction

  function automatic void push_err(input logic [2:0] code, input logic last);
    tree_res_t res;
    res = '{default: 0};
    res.kind = int'(KIND_ERR);
    res.err  = int'(code);
    res.last = 1;
    tree_results_q = {tree_results_q, res};
    clear_run_state();
    dropping = !last;
  endfunction

  // one record in, zero or more tree results out
  function automatic void tree_step(input self_id_rec_t r);
    tree_res_t    res;
    stack_entry_t e;
    int           p;
    int           reach;
    int           top1;
    int           top2;
    int           pp;
    top1 = 0;
    top2 = 0;
    if (dropping) begin
      if (r.last) begin
        dropping = 1'b0;
        clear_run_state();
      end
      return;
    end
    if (int'(r.id) != next_id || int'(r.id) >= MAX_NODES) begin
      push_err(ERR_BAD_ID, r.last);
      return;
    end
    for (p = SEEN_PORTS - 1; p >= 0; p--) begin
      if (r.ports[2*p +: 2] != PS_CHILD) continue;
      if (pend_depth == 0) begin
        push_err(ERR_EMPTY, r.last);
        return;
      end
      pend_depth--;
      e = pend_stk[pend_depth];
      res = '{default: 0};
      res.kind        = int'(KIND_LINK);
      res.parent_id   = int'(r.id);
      res.parent_port = p;
      res.child_id    = int'(e.id);
      res.child_port  = int'(e.pport);
      tree_results_q = {tree_results_q, res};
      reach = int'(e.height) + 1;
      if (reach > top1) begin
        top2 = top1;
        top1 = reach;
      end else if (reach > top2) begin
        top2 = reach;
      end
    end
    if (r.cont && r.link) begin
      irm_seen = 1'b1;
      irm_node = int'(r.id);
    end
    if (top1 + top2 > best_diam) best_diam = (top1 + top2) % 64;
    if (!r.last) begin
      pp = 16;
      for (p = 0; p < SEEN_PORTS; p++) begin
        if (pp == 16 && r.ports[2*p +: 2] == PS_PARENT) pp = p;
      end
      if (pp == 16) begin
        push_err(ERR_PARENTLESS, r.last);
        return;
      end
      if (pend_depth >= STACK_SLOTS) begin
        push_err(ERR_STACK_LEFT, r.last);
        return;
      end
      pend_stk[pend_depth] = '{height: 6'(top1), pport: 4'(pp), id: r.id};
      pend_depth++;
      next_id = (int'(r.id) + 1) % 64;
      return;
    end
    if (pend_depth != 0) begin
      push_err(ERR_STACK_LEFT, r.last);
      return;
    end
    res = '{default: 0};
    res.kind       = int'(KIND_SUM);
    res.node_count = (int'(r.id) + 1) % 64;
    res.irm_valid  = irm_seen ? 1 : 0;
    res.irm_id     = irm_seen ? irm_node : 0;
    res.diameter   = best_diam;
    res.last       = 1;
    tree_results_q = {tree_results_q, res};
    clear_run_state();
  endfunction

  task automatic add_rec(input logic [5:0] id, input logic link, input logic cont,
                         input logic [31:0] ports, input logic last, input bit hold);
    self_id_rec_t r;
    r.id         = id;
    r.link       = link;
    r.cont       = cont;
    r.ports      = ports;
    r.last       = last;
    r.hold_drain = hold;
    rec_q = {rec_q, r};
  endtask

  task automatic add_noise_rec(input logic last);
    add_rec(6'($urandom), 1'($urandom), 1'($urandom), $urandom, last, 1'b0);
  endtask

  // one bus tree in self-id order, with an optional fault somewhere in it
  task automatic gen_tree(input bit pause_first);
    int          n;
    int          d;
    int          k;
    int          kmax;
    int          id;
    int          fault_at;
    int          i;
    int          j;
    int          t;
    int          pos[16];
    fault_e      fault;
    logic [31:0] ps;
    logic [5:0]  rid;
    bit          last;
    bit          hit;
    bit          no_par;
    bit          first;
    bit          done;
    n        = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 63) : $urandom_range(1, 10);
    fault    = ($urandom_range(0, 5) == 0) ? fault_e'($urandom_range(1, 5)) : F_NONE;
    fault_at = $urandom_range(0, n - 1);
    d        = 0;
    id       = 0;
    first    = pause_first;
    done     = 1'b0;
    while (!done) begin
      last = (id >= n - 1 && d <= 16) || id == 62;
      kmax = last ? d : ((d < 15) ? d : 15);
      if (last) k = d;
      else if (d >= 8) k = $urandom_range(kmax / 2, kmax);
      else k = $urandom_range(0, kmax);
      rid    = 6'(id);
      hit    = 1'b0;
      no_par = 1'b0;
      if (fault != F_NONE && id == fault_at) begin
        case (fault)
          F_BAD_ID: begin
            rid = 6'(id + $urandom_range(1, 62));
            hit = 1'b1;
          end
          F_EXTRA_CHILD: begin
            if (d + 1 <= (last ? 16 : 15)) begin
              k   = d + 1;
              hit = 1'b1;
            end
          end
          F_NO_PARENT: begin
            if (!last) begin
              no_par = 1'b1;
              hit    = 1'b1;
            end
          end
          F_EARLY_ROOT: begin
            if (!last && d > 0) begin
              last = 1'b1;
              k    = $urandom_range(0, (d - 1 < 16) ? d - 1 : 16);
              hit  = 1'b1;
            end
          end
          default: begin
            rid = 6'd63;
            hit = 1'b1;
          end
        endcase
      end
      if (k > 16) k = 16;
      for (i = 0; i < 16; i++) pos[i] = i;
      for (i = 15; i > 0; i--) begin
        j      = $urandom_range(0, i);
        t      = pos[i];
        pos[i] = pos[j];
        pos[j] = t;
      end
      ps = '0;
      for (i = 0; i < 16; i++) begin
        if (i < k) ps[2*pos[i] +: 2] = PS_CHILD;
        else if (!no_par && $urandom_range(0, 5) == 0) ps[2*pos[i] +: 2] = PS_PARENT;
        else ps[2*pos[i] +: 2] = $urandom_range(0, 1) ? PS_UNCONN : PS_ABSENT;
      end
      if (!last && !no_par && k < 16) ps[2*pos[k] +: 2] = PS_PARENT;
      add_rec(rid, 1'($urandom), 1'($urandom), ps, last, first);
      first = 1'b0;
      n_gen++;
      d = d - k + (last ? 0 : 1);
      if (hit) begin
        // the block drops everything up to the next root marker
        if (!last) begin
          repeat ($urandom_range(0, 2)) add_noise_rec(1'b0);
          add_noise_rec(1'b1);
        end
        done = 1'b1;
      end else if (last) begin
        done = 1'b1;
      end
      id++;
    end
  endtask

  // record driver: bursts with random gaps, optional drain before an item
  always @(posedge clk_i) begin
    bit take;
    bit offer;
    take  = s_axis_tvalid && s_axis_tready;
    offer = 1'b0;
    if (rst_ni) begin
      if (take) begin
        tree_step(cur_rec);
        n_taken++;
      end
      if (!s_axis_tvalid || take) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (rec_q.size() > 0 &&
                     !(rec_q[0].hold_drain && tree_results_q.size() > 0)) begin
          cur_rec = rec_q.pop_front();
          offer   = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
        s_axis_tvalid <= offer;
        s_axis_tdata  <= {cur_rec.ports, cur_rec.cont, cur_rec.link, cur_rec.id};
        s_axis_tlast  <= cur_rec.last;
      end
    end
  end

  // result receiver: random stall modes plus one long hold-off
  rx_mode_e rx_mode   = RX_OPEN;
  int       rx_phase  = 0;
  int       hold_cnt  = 0;
  bit       long_done = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (!long_done && n_taken >= 120) begin
        long_done = 1'b1;
        hold_cnt  = 600;
        m_axis_tready <= 1'b0;
      end else begin
        rx_phase = (rx_phase + 1) % 64;
        if (rx_phase == 0) rx_mode = rx_mode_e'($urandom_range(0, 2));
        case (rx_mode)
          RX_OPEN: m_axis_tready <= 1'b1;
          RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    tree_res_t got;
    tree_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind        = int'(m_axis_tuser);
      got.parent_id   = int'(m_axis_tdata[5:0]);
      got.parent_port = int'(m_axis_tdata[9:6]);
      got.child_id    = int'(m_axis_tdata[15:10]);
      got.child_port  = int'(m_axis_tdata[19:16]);
      got.node_count  = int'(m_axis_tdata[25:20]);
      got.irm_valid   = int'(m_axis_tdata[26]);
      got.irm_id      = int'(m_axis_tdata[32:27]);
      got.diameter    = int'(m_axis_tdata[38:33]);
      got.err         = int'(m_axis_tdata[41:39]);
      got.pad         = int'(m_axis_tdata[47:42]);
      got.last        = int'(m_axis_tlast);
      case (m_axis_tuser)
        KIND_LINK: n_links++;
        KIND_SUM:  n_sums++;
        default:   n_errs++;
      endcase
      if (tree_results_q.size() == 0) begin
        flag_mismatch($sformatf("result kind %0d with nothing pending", got.kind));
      end else begin
        want = tree_results_q.pop_front();
        cmp_field("result_kind", got.kind, want.kind);
        cmp_field("parent_id", got.parent_id, want.parent_id);
        cmp_field("parent_port", got.parent_port, want.parent_port);
        cmp_field("child_id", got.child_id, want.child_id);
        cmp_field("child_port", got.child_port, want.child_port);
        cmp_field("node_count", got.node_count, want.node_count);
        cmp_field("irm_valid", got.irm_valid, want.irm_valid);
        cmp_field("irm_id", got.irm_id, want.irm_id);
        cmp_field("diameter_hops", got.diameter, want.diameter);
        cmp_field("error_code", got.err, want.err);
        cmp_field("pad bits", got.pad, want.pad);
        cmp_field("last_of_run", got.last, want.last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               tree_results_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int seq;
    // lone root that is also the irm
    add_rec(6'd0, 1'b1, 1'b1, 32'h5555_5555, 1'b1, 1'b0);
    // invalid id on a root record
    add_rec(6'd63, 1'b1, 1'b1, 32'h0000_0000, 1'b1, 1'b0);
    // leaf on port 15, root with a stray parent port
    add_rec(6'd0, 1'b1, 1'b1, 32'h8000_0000, 1'b0, 1'b0);
    add_rec(6'd1, 1'b0, 1'b1, 32'h0000_0083, 1'b1, 1'b0);
    // child port with empty stack, then dropped records
    add_rec(6'd0, 1'b0, 1'b0, 32'h0000_000E, 1'b0, 1'b0);
    add_rec(6'd5, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0);
    add_rec(6'd0, 1'b0, 1'b0, 32'h0000_0000, 1'b1, 1'b0);
    // non-root without a parent port
    add_rec(6'd0, 1'b1, 1'b0, 32'h5555_5555, 1'b0, 1'b0);
    add_rec(6'd0, 1'b1, 1'b1, 32'h0000_0002, 1'b1, 1'b0);
    // root leaves a node unresolved
    add_rec(6'd0, 1'b0, 1'b0, 32'h0000_0002, 1'b0, 1'b0);
    add_rec(6'd1, 1'b0, 1'b0, 32'h0000_0001, 1'b1, 1'b0);
    // skipped id
    add_rec(6'd0, 1'b0, 1'b0, 32'h0000_0002, 1'b0, 1'b0);
    add_rec(6'd2, 1'b0, 1'b0, 32'h0000_0003, 1'b0, 1'b0);
    add_rec(6'd1, 1'b0, 1'b0, 32'h0000_0003, 1'b1, 1'b0);
    // one link made before the stack runs dry
    add_rec(6'd0, 1'b1, 1'b1, 32'h0000_0002, 1'b0, 1'b0);
    add_rec(6'd1, 1'b1, 1'b1, 32'h0000_000F, 1'b0, 1'b0);
    add_rec(6'd2, 1'b0, 1'b0, 32'h0000_0000, 1'b1, 1'b0);
    // three-node chain
    add_rec(6'd0, 1'b0, 1'b0, 32'h0000_0002, 1'b0, 1'b0);
    add_rec(6'd1, 1'b1, 1'b1, 32'h0000_000B, 1'b0, 1'b0);
    add_rec(6'd2, 1'b0, 1'b0, 32'hC000_0000, 1'b1, 1'b0);

    seq = 0;
    while (n_gen < RANDOM_RECS) begin
      if ($urandom_range(0, 19) == 0) add_noise_rec(($urandom_range(0, 3) != 0));
      gen_tree(seq % 25 == 10);
      seq++;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (rec_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (tree_results_q.size() > 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d records in, %0d links, %0d summaries, %0d error results",
             n_taken, n_links, n_sums, n_errs);
    $display("%0d mismatches in %0d cycles", err_count, cycle_cnt);
    if (err_count == 0 && tree_results_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
